// ----- rtl/core/slpg_pkg.sv -----
// ----------------------------------------------------------------------------
// slpg_pkg
// Shared constants for the slotted leaf page store: default geometry, entry
// layout, command and status codes, and fixed field widths.
// ----------------------------------------------------------------------------
package slpg_pkg;

    // Default page geometry
    localparam int PAGE_BYTES_DEF   = 4096;
    localparam int HEADER_BYTES_DEF = 16;
    localparam int MAX_ENTRIES_DEF  = 255;

    // Entry table slot layout in page bytes: key, offset, length
    localparam int KEY_BYTES    = 4;
    localparam int OFFSET_BYTES = 8;
    localparam int LENGTH_BYTES = 4;
    localparam int ENTRY_BYTES  = KEY_BYTES + OFFSET_BYTES + LENGTH_BYTES;

    // Fixed field widths
    localparam int CMD_W    = 2;
    localparam int KEY_W    = 32;
    localparam int LEN_W    = 12;
    localparam int BYTE_W   = 8;
    localparam int ADDR_W   = 12;
    localparam int STATUS_W = 3;
    localparam int OFF_W    = 12;

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;

    // Commands
    localparam t_cmd CMD_FIND      = 2'd0;
    localparam t_cmd CMD_INSERT    = 2'd1;
    localparam t_cmd CMD_BYTE      = 2'd2;
    localparam t_cmd CMD_READ      = 2'd3;

    // Result status codes
    localparam t_status ST_FOUND     = 3'd0;
    localparam t_status ST_NOT_FOUND = 3'd1;
    localparam t_status ST_INSERTED  = 3'd2;
    localparam t_status ST_NO_SPACE  = 3'd3;
    localparam t_status ST_STORED    = 3'd4;
    localparam t_status ST_IGNORED   = 3'd5;
    localparam t_status ST_READ_DATA = 3'd6;

endpackage

// ----- rtl/core/slpg_ram.sv -----
// ----------------------------------------------------------------------------
// slpg_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. Contents are undefined until written.
// ----------------------------------------------------------------------------
module slpg_ram #(
    parameter int WIDTH = slpg_pkg::BYTE_W,
    parameter int DEPTH = slpg_pkg::PAGE_BYTES_DEF,
    localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [IW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [IW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/slotted_leaf_page_store.sv -----
// Sequencing: insert and byte items are executed in S_EXEC; a read also passes S_RDOUT,
// and a find runs P probes (at most 8 probes for 255 entries).
// Throughput: one transaction at a time; ready returns the cycle after the result is taken.
// Each probe has two steps: an entry table read and a key compare.
// Reset clears the sequencer, entry count, record start, fill pointer and run flag;
// the entry table and page byte memories are not cleared.
// ----------------------------------------------------------------------------
// slotted_leaf_page_store
// Leaf page store: entry table grows upward after the header, record bytes
// grow downward from the page end. Serves find (binary search), insert begin,
// record byte fill and page byte read, one transaction at a time.
// ----------------------------------------------------------------------------
module slotted_leaf_page_store #(
    parameter int PAGE_BYTES   = slpg_pkg::PAGE_BYTES_DEF,
    parameter int HEADER_BYTES = slpg_pkg::HEADER_BYTES_DEF,
    parameter int MAX_ENTRIES  = slpg_pkg::MAX_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  slpg_pkg::t_cmd                i_cmd,
    input  logic [slpg_pkg::KEY_W-1:0]    i_search_key,
    input  logic [slpg_pkg::LEN_W-1:0]    i_record_length,
    input  logic [slpg_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic [slpg_pkg::ADDR_W-1:0]   i_read_address,
    input  logic                          i_last,
    // Output channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output slpg_pkg::t_status             o_status,
    output logic [slpg_pkg::OFF_W-1:0]    o_value_offset,
    output logic [slpg_pkg::LEN_W-1:0]    o_value_length,
    output logic [slpg_pkg::BYTE_W-1:0]   o_read_byte
);

    import slpg_pkg::*;

    // Widths
    localparam int AW  = $clog2(PAGE_BYTES);                 // page byte index
    localparam int PW  = $clog2(PAGE_BYTES + 1);             // page position incl. end
    localparam int CW  = $clog2(MAX_ENTRIES + 1);            // entry count
    localparam int EW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int UW  = $clog2(HEADER_BYTES + (MAX_ENTRIES + 1) * ENTRY_BYTES
                                + PAGE_BYTES + (1 << LEN_W) + 1);
    localparam int EDW = KEY_W + OFF_W + LEN_W;              // entry word

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_PROBE = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_RDOUT = 3'd4;

    logic [2:0]        r_state,   n_state;

    // Latched transaction
    t_cmd              r_cmd,     n_cmd;
    logic [KEY_W-1:0]  r_key,     n_key;
    logic [LEN_W-1:0]  r_len,     n_len;
    logic [BYTE_W-1:0] r_byte,    n_byte;
    logic [ADDR_W-1:0] r_addr,    n_addr;
    logic              r_last,    n_last;

    // Page bookkeeping
    logic [CW-1:0]     r_count,   n_count;
    logic [PW-1:0]     r_start,   n_start;
    logic [PW-1:0]     r_fill,    n_fill;
    logic [PW-1:0]     r_run_end, n_run_end;
    logic              r_open,    n_open;

    // Search window
    logic [CW-1:0]     r_lo,      n_lo;
    logic [CW-1:0]     r_hx,      n_hx;
    logic [CW-1:0]     r_mid,     n_mid;

    // Result register
    logic              r_out_valid, n_out_valid;
    t_status           r_out_status, n_out_status;
    logic [OFF_W-1:0]  r_out_off,  n_out_off;
    logic [LEN_W-1:0]  r_out_len,  n_out_len;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;

    // Memory ports
    logic              ent_wr_en;
    logic [EW-1:0]     ent_wr_addr;
    logic [EDW-1:0]    ent_wr_data;
    logic              ent_rd_en;
    logic [EDW-1:0]    ent_rd_data;
    logic              pg_wr_en;
    logic              pg_rd_en;
    logic [BYTE_W-1:0] pg_rd_data;

    // Shared datapath
    logic [CW-1:0]     w_mid;
    logic [CW-1:0]     w_mid_inc;
    logic [UW-1:0]     w_need;
    logic              w_fits;
    logic [PW-1:0]     w_new_off;
    logic              w_addr_ok;
    logic [KEY_W-1:0]  w_probe_key;

    // Probe midpoint: lo + (hi_inclusive - lo) / 2
    assign w_mid     = r_lo + ((r_hx - r_lo - CW'(1)) >> 1);
    assign w_mid_inc = r_mid + CW'(1);

    // Free space check: header + table + one slot + record must fit below records
    assign w_need    = UW'(HEADER_BYTES) + UW'(r_count) * UW'(ENTRY_BYTES)
                     + UW'(ENTRY_BYTES) + UW'(r_len);
    assign w_fits    = (r_count < CW'(MAX_ENTRIES)) && (UW'(r_start) >= w_need);
    assign w_new_off = PW'(UW'(r_start) - UW'(r_len));

    assign w_addr_ok   = UW'(r_addr) < UW'(PAGE_BYTES);
    assign w_probe_key = ent_rd_data[EDW-1 -: KEY_W];

    assign ent_wr_addr = r_count[EW-1:0];
    assign ent_wr_data = {r_key, OFF_W'(w_new_off), r_len};

    // Sequencer next state and datapath control
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_len        = r_len;
        n_byte       = r_byte;
        n_addr       = r_addr;
        n_last       = r_last;
        n_count      = r_count;
        n_start      = r_start;
        n_fill       = r_fill;
        n_run_end    = r_run_end;
        n_open       = r_open;
        n_lo         = r_lo;
        n_hx         = r_hx;
        n_mid        = r_mid;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_off    = r_out_off;
        n_out_len    = r_out_len;
        n_out_byte   = r_out_byte;
        ent_wr_en    = 1'b0;
        ent_rd_en    = 1'b0;
        pg_wr_en     = 1'b0;
        pg_rd_en     = 1'b0;

        // Drop the result once taken
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_cmd   = i_cmd;
                    n_key   = i_search_key;
                    n_len   = i_record_length;
                    n_byte  = i_data_byte;
                    n_addr  = i_read_address;
                    n_last  = i_last;
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_out_off  = '0;
                n_out_len  = '0;
                n_out_byte = '0;
                unique case (r_cmd)
                    CMD_FIND: begin
                        if (r_count == '0) begin
                            n_out_valid  = 1'b1;
                            n_out_status = ST_NOT_FOUND;
                            n_state      = S_IDLE;
                        end else begin
                            n_lo    = '0;
                            n_hx    = r_count;
                            n_state = S_PROBE;
                        end
                    end
                    CMD_INSERT: begin
                        // A new insert abandons any open run
                        n_open      = 1'b0;
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                        if (w_fits) begin
                            ent_wr_en    = 1'b1;
                            n_count      = r_count + CW'(1);
                            n_start      = w_new_off;
                            n_fill       = w_new_off;
                            n_run_end    = r_start;
                            n_open       = (r_len != '0);
                            n_out_status = ST_INSERTED;
                            n_out_off    = OFF_W'(w_new_off);
                            n_out_len    = r_len;
                        end else begin
                            n_out_status = ST_NO_SPACE;
                        end
                    end
                    CMD_BYTE: begin
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                        if (r_open && (r_fill < r_run_end)) begin
                            pg_wr_en     = 1'b1;
                            n_fill       = r_fill + PW'(1);
                            n_open       = !(r_last || (n_fill >= r_run_end));
                            n_out_status = ST_STORED;
                        end else begin
                            n_open       = 1'b0;
                            n_out_status = ST_IGNORED;
                        end
                    end
                    CMD_READ: begin
                        pg_rd_en = 1'b1;
                        n_state  = S_RDOUT;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_PROBE: begin
                // Issue the entry table read at the midpoint
                ent_rd_en = 1'b1;
                n_mid     = w_mid;
                n_state   = S_CMP;
            end

            S_CMP: begin
                if (r_key == w_probe_key) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_FOUND;
                    n_out_off    = ent_rd_data[LEN_W +: OFF_W];
                    n_out_len    = ent_rd_data[LEN_W-1:0];
                    n_state      = S_IDLE;
                end else if (r_key < w_probe_key) begin
                    n_hx = r_mid;
                    if (r_lo < r_mid) begin
                        n_state = S_PROBE;
                    end else begin
                        n_out_valid  = 1'b1;
                        n_out_status = ST_NOT_FOUND;
                        n_state      = S_IDLE;
                    end
                end else begin
                    n_lo = w_mid_inc;
                    if (w_mid_inc < r_hx) begin
                        n_state = S_PROBE;
                    end else begin
                        n_out_valid  = 1'b1;
                        n_out_status = ST_NOT_FOUND;
                        n_state      = S_IDLE;
                    end
                end
            end

            S_RDOUT: begin
                n_out_valid  = 1'b1;
                n_out_status = ST_READ_DATA;
                n_out_byte   = w_addr_ok ? pg_rd_data : '0;
                n_state      = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_start     <= PW'(PAGE_BYTES);
            r_fill      <= '0;
            r_open      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_start     <= n_start;
            r_fill      <= n_fill;
            r_open      <= n_open;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and search registers
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_len        <= n_len;
        r_byte       <= n_byte;
        r_addr       <= n_addr;
        r_last       <= n_last;
        r_run_end    <= n_run_end;
        r_lo         <= n_lo;
        r_hx         <= n_hx;
        r_mid        <= n_mid;
        r_out_status <= n_out_status;
        r_out_off    <= n_out_off;
        r_out_len    <= n_out_len;
        r_out_byte   <= n_out_byte;
    end

    // Entry table: key, record offset, record length
    slpg_ram #(
        .WIDTH (EDW),
        .DEPTH (MAX_ENTRIES)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ent_wr_en),
        .i_wr_addr (ent_wr_addr),
        .i_wr_data (ent_wr_data),
        .i_rd_en   (ent_rd_en),
        .i_rd_addr (w_mid[EW-1:0]),
        .o_rd_data (ent_rd_data)
    );

    // Page record bytes
    slpg_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PAGE_BYTES)
    ) u_page_ram (
        .i_clk     (i_clk),
        .i_wr_en   (pg_wr_en),
        .i_wr_addr (r_fill[AW-1:0]),
        .i_wr_data (r_byte),
        .i_rd_en   (pg_rd_en),
        .i_rd_addr (AW'(r_addr)),
        .o_rd_data (pg_rd_data)
    );

    // Ports
    assign o_ready        = (r_state == S_IDLE) && !r_out_valid;
    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_value_offset = r_out_off;
    assign o_value_length = r_out_len;
    assign o_read_byte    = r_out_byte;

    // An open run always has room left in its record
    a_open_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open |-> (r_fill < r_run_end))
        else $error("open run with fill pointer at or past record end");

    // Table and record area stay inside their bounds
    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CW'(MAX_ENTRIES)) && (r_start <= PW'(PAGE_BYTES)))
        else $error("entry count or record start out of range");

    // An accepted transaction is executed in the next cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_EXEC))
        else $error("accepted transaction not executed");

    // A search window is never empty while probing
    a_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_lo < r_hx))
        else $error("empty search window at probe");

    // Only found or inserted results carry offset and length
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != ST_FOUND) && (r_out_status != ST_INSERTED))
        |-> ((r_out_off == '0) && (r_out_len == '0)))
        else $error("offset or length set on a result without an entry");

endmodule

// ----- verif/tb_slotted_leaf_page_store.sv -----
// ----------------------------------------------------------------------------
// tb_slotted_leaf_page_store
// Self-checking bench for the slotted leaf page store. A short stimulus table
// covers the empty page, zero-length records, run ends, abandoned runs and
// refusals. Random insert runs with mostly ascending keys follow, mixed with
// finds, reads of written bytes and noise. Every reply is checked against a
// typed reply or an in-bench page predictor, with random idle bursts on both
// channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_slotted_leaf_page_store;
    timeunit 1ns;
    timeprecision 1ps;

    import slpg_pkg::*;

    // Default page geometry and entry table depth
    localparam int PG_BYTES    = PAGE_BYTES_DEF;
    localparam int HDR_SIZE    = HEADER_BYTES_DEF;
    localparam int TABLE_SLOTS = MAX_ENTRIES_DEF;
    localparam int CYCLE_LIMIT = 500000;
    localparam int ITEM_TARGET = 950;
    localparam int TAIL_START  = 880;

    typedef struct packed {
        t_cmd              cmd;
        logic [KEY_W-1:0]  key;
        logic [LEN_W-1:0]  rec_len;
        logic [BYTE_W-1:0] data;
        logic [ADDR_W-1:0] addr;
        logic              last;
    } t_page_item;

    typedef struct packed {
        t_status           status;
        logic [OFF_W-1:0]  offset;
        logic [LEN_W-1:0]  length;
        logic [BYTE_W-1:0] rd_byte;
    } t_page_reply;

    typedef struct packed {
        t_page_item  item;
        logic        typed;
        t_page_reply reply;
    } t_page_row;

    localparam t_page_reply NO_REPLY = '0;

    // Directed table: typed replies where they are obvious, predictor otherwise
    t_page_row directed_rows [25] = '{
        '{'{CMD_FIND,   32'h0,        12'd0,    8'h00, 12'd0,    1'b0}, 1'b1,
          '{ST_NOT_FOUND, 12'd0,    12'd0, 8'h00}},
        '{'{CMD_BYTE,   32'h0,        12'd0,    8'h00, 12'd0,    1'b0}, 1'b1,
          '{ST_IGNORED,   12'd0,    12'd0, 8'h00}},
        // zero-length record at the page end: offset wraps to zero
        '{'{CMD_INSERT, 32'h0,        12'd0,    8'h00, 12'd0,    1'b0}, 1'b1,
          '{ST_INSERTED,  12'd0,    12'd0, 8'h00}},
        '{'{CMD_BYTE,   32'h0,        12'd0,    8'h00, 12'd0,    1'b0}, 1'b1,
          '{ST_IGNORED,   12'd0,    12'd0, 8'h00}},
        '{'{CMD_INSERT, 32'h10,       12'd4,    8'h00, 12'd0,    1'b0}, 1'b1,
          '{ST_INSERTED,  12'd4092, 12'd4, 8'h00}},
        '{'{CMD_BYTE,   32'h0,        12'd0,    8'h00, 12'd0,    1'b0}, 1'b0, NO_REPLY},
        '{'{CMD_BYTE,   32'h0,        12'd0,    8'hff, 12'd0,    1'b0}, 1'b0, NO_REPLY},
        // find and read while the run is open
        '{'{CMD_FIND,   32'h10,       12'd0,    8'h00, 12'd0,    1'b0}, 1'b1,
          '{ST_FOUND,     12'd4092, 12'd4, 8'h00}},
        '{'{CMD_READ,   32'h0,        12'd0,    8'h00, 12'd4092, 1'b0}, 1'b1,
          '{ST_READ_DATA, 12'd0,    12'd0, 8'h00}},
        '{'{CMD_BYTE,   32'h0,        12'd0,    8'ha5, 12'd0,    1'b0}, 1'b0, NO_REPLY},
        '{'{CMD_BYTE,   32'h0,        12'd0,    8'h5a, 12'd0,    1'b1}, 1'b0, NO_REPLY},
        '{'{CMD_BYTE,   32'h0,        12'd0,    8'h77, 12'd0,    1'b0}, 1'b1,
          '{ST_IGNORED,   12'd0,    12'd0, 8'h00}},
        '{'{CMD_INSERT, 32'h20,       12'd3,    8'h00, 12'd0,    1'b0}, 1'b1,
          '{ST_INSERTED,  12'd4089, 12'd3, 8'h00}},
        // last closes the run early
        '{'{CMD_BYTE,   32'h0,        12'd0,    8'h11, 12'd0,    1'b1}, 1'b0, NO_REPLY},
        '{'{CMD_BYTE,   32'h0,        12'd0,    8'h22, 12'd0,    1'b0}, 1'b1,
          '{ST_IGNORED,   12'd0,    12'd0, 8'h00}},
        // abandon a run with a new insert
        '{'{CMD_INSERT, 32'h30,       12'd2,    8'h00, 12'd0,    1'b0}, 1'b0, NO_REPLY},
        '{'{CMD_BYTE,   32'h0,        12'd0,    8'h33, 12'd0,    1'b0}, 1'b0, NO_REPLY},
        '{'{CMD_INSERT, 32'h40,       12'd1,    8'h00, 12'd0,    1'b0}, 1'b0, NO_REPLY},
        '{'{CMD_BYTE,   32'h0,        12'd0,    8'h44, 12'd0,    1'b0}, 1'b0, NO_REPLY},
        '{'{CMD_INSERT, 32'h50,       12'd4064, 8'h00, 12'd0,    1'b0}, 1'b1,
          '{ST_NO_SPACE,  12'd0,    12'd0, 8'h00}},
        '{'{CMD_READ,   32'h0,        12'd0,    8'h00, 12'd4095, 1'b0}, 1'b1,
          '{ST_READ_DATA, 12'd0,    12'd0, 8'h5a}},
        '{'{CMD_READ,   32'h0,        12'd0,    8'h00, 12'd4093, 1'b0}, 1'b0, NO_REPLY},
        '{'{CMD_FIND,   32'hffffffff, 12'd0,    8'h00, 12'd0,    1'b0}, 1'b1,
          '{ST_NOT_FOUND, 12'd0,    12'd0, 8'h00}},
        '{'{CMD_FIND,   32'h0,        12'd0,    8'h00, 12'd0,    1'b0}, 1'b0, NO_REPLY},
        '{'{CMD_FIND,   32'h35,       12'd0,    8'h00, 12'd0,    1'b0}, 1'b0, NO_REPLY}
    };

    // DUT ports
    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_valid         = 1'b0;
    logic              o_ready;
    t_cmd              i_cmd           = CMD_FIND;
    logic [KEY_W-1:0]  i_search_key    = '0;
    logic [LEN_W-1:0]  i_record_length = '0;
    logic [BYTE_W-1:0] i_data_byte     = '0;
    logic [ADDR_W-1:0] i_read_address  = '0;
    logic              i_last          = 1'b0;
    logic              o_valid;
    logic              i_ready         = 1'b0;
    t_status           o_status;
    logic [OFF_W-1:0]  o_value_offset;
    logic [LEN_W-1:0]  o_value_length;
    logic [BYTE_W-1:0] o_read_byte;

    // Predicted page contents
    logic [KEY_W-1:0]  tbl_key [TABLE_SLOTS];
    int                tbl_off [TABLE_SLOTS];
    int                tbl_len [TABLE_SLOTS];
    logic [BYTE_W-1:0] page_image [PG_BYTES];
    int                written_addrs [$];
    int                n_entries = 0;
    int                rec_start = PG_BYTES;
    int                fill_ptr  = 0;
    bit                run_open  = 1'b0;

    t_page_reply       pending_replies [$];
    int                fail_count    = 0;
    int                replies_seen  = 0;
    int                items_counted = 0;
    bit                quiet_tail    = 1'b0;
    bit                hold_off      = 1'b0;
    bit                sender_calm   = 1'b0;
    bit                recv_calm     = 1'b0;
    int                stall_left    = 0;

    slotted_leaf_page_store #(
        .MAX_ENTRIES (TABLE_SLOTS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_cmd           (i_cmd),
        .i_search_key    (i_search_key),
        .i_record_length (i_record_length),
        .i_data_byte     (i_data_byte),
        .i_read_address  (i_read_address),
        .i_last          (i_last),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_value_offset  (o_value_offset),
        .o_value_length  (o_value_length),
        .o_read_byte     (o_read_byte)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Apply one transaction to the predicted page and return its reply
    function automatic t_page_reply predict_page_reply(t_page_item it);
        t_page_reply r;
        int lo, hi, mid, used, avail, rec_end;
        r = '0;
        case (it.cmd)
            CMD_FIND: begin
                r.status = ST_NOT_FOUND;
                lo = 0;
                hi = n_entries - 1;
                while (lo <= hi) begin
                    mid = lo + (hi - lo) / 2;
                    if (it.key == tbl_key[mid]) begin
                        // offsets truncate to the port width
                        r.status = ST_FOUND;
                        r.offset = OFF_W'(tbl_off[mid]);
                        r.length = LEN_W'(tbl_len[mid]);
                        lo = hi + 1;
                    end else if (it.key < tbl_key[mid]) begin
                        hi = mid - 1;
                    end else begin
                        lo = mid + 1;
                    end
                end
            end
            CMD_INSERT: begin
                used  = HDR_SIZE + n_entries * ENTRY_BYTES;
                avail = (rec_start > used) ? rec_start - used : 0;
                run_open = 1'b0;
                if (n_entries >= TABLE_SLOTS || avail < ENTRY_BYTES + int'(it.rec_len)) begin
                    r.status = ST_NO_SPACE;
                end else begin
                    rec_start = rec_start - int'(it.rec_len);
                    tbl_key[n_entries] = it.key;
                    tbl_off[n_entries] = rec_start;
                    tbl_len[n_entries] = int'(it.rec_len);
                    n_entries++;
                    fill_ptr = rec_start;
                    run_open = (it.rec_len != 0);
                    r.status = ST_INSERTED;
                    r.offset = OFF_W'(rec_start);
                    r.length = it.rec_len;
                end
            end
            CMD_BYTE: begin
                if (!run_open || n_entries == 0) begin
                    r.status = ST_IGNORED;
                end else begin
                    rec_end = tbl_off[n_entries-1] + tbl_len[n_entries-1];
                    if (fill_ptr >= rec_end || fill_ptr >= PG_BYTES) begin
                        run_open = 1'b0;
                        r.status = ST_IGNORED;
                    end else begin
                        page_image[fill_ptr] = it.data;
                        written_addrs.push_back(fill_ptr);
                        fill_ptr++;
                        if (it.last || fill_ptr >= rec_end)
                            run_open = 1'b0;
                        r.status = ST_STORED;
                    end
                end
            end
            default: begin
                r.status  = ST_READ_DATA;
                r.rd_byte = (int'(it.addr) < PG_BYTES) ? page_image[it.addr] : '0;
            end
        endcase
        return r;
    endfunction

    // Random content in every field; callers override what matters
    function automatic t_page_item rand_fields();
        t_page_item it;
        it.cmd     = CMD_FIND;
        it.key     = $urandom;
        it.rec_len = LEN_W'($urandom_range(0, 4064));
        it.data    = BYTE_W'($urandom_range(0, 255));
        it.addr    = ADDR_W'($urandom_range(0, 4095));
        it.last    = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Mostly keys that are present, some neighbors and random keys
    function automatic t_page_item make_find();
        t_page_item it;
        int pick;
        it   = rand_fields();
        pick = $urandom_range(0, 9);
        if (n_entries > 0 && pick < 7) begin
            it.key = tbl_key[$urandom_range(0, n_entries - 1)];
            if (pick == 6)
                it.key = it.key + 1;
        end
        return it;
    endfunction

    // Read only bytes that have been written
    function automatic t_page_item make_read();
        t_page_item it;
        if (written_addrs.size() == 0)
            return make_find();
        it      = rand_fields();
        it.cmd  = CMD_READ;
        it.addr = ADDR_W'(written_addrs[$urandom_range(0, written_addrs.size() - 1)]);
        return it;
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("ERROR: %s", msg);
    endfunction

    // Present one transaction, hold it until accepted, then maybe idle
    task automatic offer_item(input t_page_item it, input bit typed,
                              input t_page_reply typed_reply);
        t_page_reply predicted;
        i_valid         <= 1'b1;
        i_cmd           <= it.cmd;
        i_search_key    <= it.key;
        i_record_length <= it.rec_len;
        i_data_byte     <= it.data;
        i_read_address  <= it.addr;
        i_last          <= it.last;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        predicted = predict_page_reply(it);
        pending_replies.push_back(typed ? typed_reply : predicted);
        items_counted++;
        if ($urandom_range(0, 49) == 0)
            sender_calm = !sender_calm;
        if (!quiet_tail && !sender_calm && $urandom_range(0, 2) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    // Compare each reply with the oldest prediction
    task automatic check_reply();
        t_page_reply want;
        if (pending_replies.size() == 0) begin
            note_failure($sformatf("reply with no transaction pending: status %0d", o_status));
        end else begin
            want = pending_replies.pop_front();
            if (o_status !== want.status || o_value_offset !== want.offset ||
                o_value_length !== want.length || o_read_byte !== want.rd_byte)
                note_failure($sformatf(
                    "reply mismatch: status %0d/%0d offset %0d/%0d length %0d/%0d byte %02h/%02h (exp/got)",
                    want.status, o_status, want.offset, o_value_offset,
                    want.length, o_value_length, want.rd_byte, o_read_byte));
        end
    endtask

    // Receive side: take replies, stall in random bursts
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            replies_seen <= replies_seen + 1;
            check_reply();
        end
        if ($urandom_range(0, 79) == 0)
            recv_calm = !recv_calm;
        if (hold_off) begin
            i_ready <= 1'b0;
        end else if (quiet_tail || recv_calm) begin
            i_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if ($urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 14);
        end
    end

    // Hold the receiver off for a long stretch while the sender keeps offering
    initial begin : hold_off_stretch
        wait (replies_seen >= 300);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin : watchdog
        int unsigned cycles;
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
            @(posedge i_clk);
        $display("tb_slotted_leaf_page_store: FAIL");
        $finish;
    end

    // Stimulus
    initial begin : stimulus
        t_page_item   it;
        logic [31:0]  next_key;
        int           r, len, nb, last_pos, k, used, avail, min_refuse;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (directed_rows[i])
            offer_item(directed_rows[i].item, directed_rows[i].typed,
                       directed_rows[i].reply);

        // random part: ascending keys keep the search reliable
        next_key = 32'h100;
        while (items_counted < ITEM_TARGET) begin
            if (items_counted >= TAIL_START)
                quiet_tail <= 1'b1;
            r = $urandom_range(0, 99);
            if (r < 55) begin
                // insert begin followed by its byte run
                it     = rand_fields();
                it.cmd = CMD_INSERT;
                if ($urandom_range(0, 19) == 0) begin
                    it.key = $urandom;
                end else begin
                    it.key   = next_key;
                    next_key = next_key + $urandom_range(1, 1 << 24);
                end
                k = $urandom_range(0, 99);
                if (k < 85)
                    len = $urandom_range(0, 4);
                else if (k < 98)
                    len = $urandom_range(5, 16);
                else
                    len = $urandom_range(17, 48);
                it.rec_len = LEN_W'(len);
                offer_item(it, 1'b0, NO_REPLY);

                case ($urandom_range(0, 9))
                    0: begin
                        // abandon part way
                        nb       = (len > 0) ? $urandom_range(0, len - 1) : 0;
                        last_pos = -1;
                    end
                    1: begin
                        // close early with last
                        nb       = (len > 0) ? $urandom_range(1, len) : 0;
                        last_pos = nb - 1;
                    end
                    2: begin
                        // one byte past the record end
                        nb       = len + 1;
                        last_pos = -1;
                    end
                    default: begin
                        nb       = len;
                        last_pos = $urandom_range(0, 1) ? len - 1 : -1;
                    end
                endcase
                for (k = 0; k < nb; k++) begin
                    if ($urandom_range(0, 7) == 0)
                        offer_item($urandom_range(0, 1) ? make_find() : make_read(),
                                   1'b0, NO_REPLY);
                    it      = rand_fields();
                    it.cmd  = CMD_BYTE;
                    it.last = (k == last_pos);
                    offer_item(it, 1'b0, NO_REPLY);
                end
            end else if (r < 75) begin
                offer_item(make_find(), 1'b0, NO_REPLY);
            end else if (r < 92) begin
                offer_item(make_read(), 1'b0, NO_REPLY);
            end else begin
                // noise: stray byte or an insert too large for the free space
                it    = rand_fields();
                used  = HDR_SIZE + n_entries * ENTRY_BYTES;
                avail = (rec_start > used) ? rec_start - used : 0;
                min_refuse = (avail > ENTRY_BYTES) ? avail - ENTRY_BYTES + 1 : 0;
                if ($urandom_range(0, 1) || min_refuse > 4064) begin
                    it.cmd = CMD_BYTE;
                end else begin
                    it.cmd     = CMD_INSERT;
                    it.rec_len = LEN_W'($urandom_range(0, 1) ? min_refuse
                                        : $urandom_range(min_refuse, 4064));
                end
                offer_item(it, 1'b0, NO_REPLY);
            end
        end
        i_valid <= 1'b0;

        // drain outstanding replies, then allow for the longest find
        while (pending_replies.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (fail_count == 0 && pending_replies.size() == 0)
            $display("tb_slotted_leaf_page_store: PASS");
        else
            $display("tb_slotted_leaf_page_store: FAIL");
        $finish;
    end

endmodule
